// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the timer table RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TMR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TMR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

// ----- rtl/core/tmr_pkg.sv -----
`default_nettype none
package tmr_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int MAX_FIRE_DEF  = 63;
  localparam int TIME_BITS_DEF = 48;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 6;
  localparam int PER_W    = 32;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_AT    = 3'd0,
    OP_ADD_AFTER = 3'd1,
    OP_PAUSE     = 3'd2,
    OP_RESUME    = 3'd3,
    OP_CANCEL    = 3'd4,
    OP_RUN       = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Commands broadcast from the sequencer to the row of cells.
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_RESUME   = 3'd3,
    CMD_FREE     = 3'd4,
    CMD_ADVANCE  = 3'd5,
    CMD_SET_EXP  = 3'd6,
    CMD_CLR_SEEN = 3'd7
  } cell_cmd_t;

  // What the search token looks for while it walks the row.
  typedef enum logic [1:0] {
    SCAN_FREE = 2'd0,
    SCAN_DUE  = 2'd1,
    SCAN_NEXT = 2'd2
  } scan_mode_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    scan_mode_t mode;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/periodic_timer_table_top.sv -----
`default_nettype none
`include "assert_macros.svh"
// Periodic timer table. NUM_SLOTS timer slots sit in a row of cells; each cell
// holds one slot's active and paused marks, its expiry and its repeat period.
// A search token walks the row one cell per clock and comes out of the far end
// carrying the winning slot, which the sequencer then acts on. Pause, resume
// and cancel need no search. An add makes one search for the lowest free slot.
// A run repeats the search for each fire result and each paused due timer that
// it handles, and each paused periodic timer also needs a bit-serial remainder
// for its new expiry. Input is taken only while the sequencer is idle; a result
// transaction waiting on the output does not stop the next input transaction
// from being accepted, since results leave through an output register. After
// reset all slots are free; no clearing pass runs.
module periodic_timer_table_top
  import tmr_pkg::*;
#(
  parameter int NUM_SLOTS = tmr_pkg::NUM_SLOTS_DEF,
  parameter int MAX_FIRE  = tmr_pkg::MAX_FIRE_DEF,
  parameter int TIME_BITS = tmr_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmr_pkg::OP_W-1:0]      operation,
  input  logic [tmr_pkg::SLOT_W-1:0]    slot,
  input  logic [TIME_BITS-1:0]          time_value,
  input  logic [tmr_pkg::PER_W-1:0]     interval,
  input  logic [TIME_BITS-1:0]          now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmr_pkg::KIND_W-1:0]    kind,
  output logic [tmr_pkg::SLOT_W-1:0]    slot_out,
  output logic [tmr_pkg::STAT_W-1:0]    status,
  output logic [TIME_BITS-1:0]          next_expiry,
  output logic                          next_valid,
  output logic [tmr_pkg::CNT_OUT_W-1:0] active_count,
  output logic                          more_pending,
  output logic                          last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_DIV    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t               state;
  scan_mode_t           scan_mode;
  logic [IW-1:0]        scan_cnt;

  // Transaction being worked on.
  op_t                  op_q;
  logic [TIME_BITS-1:0] tv_q;
  logic [PER_W-1:0]     per_q;
  logic [TIME_BITS-1:0] now_q;

  logic [FW-1:0]        fires;
  logic                 more;
  logic [CW-1:0]        active_cnt;
  logic [IW-1:0]        win_idx;
  logic [PER_W-1:0]     win_per;

  // Result staged for the output register, with the slot update that goes with it.
  cell_cmd_t            pend_cmd;
  logic [IW-1:0]        pend_idx;
  logic [CW-1:0]        pend_cnt;
  kind_t                pend_kind;
  logic [SLOT_W-1:0]    pend_slot;
  status_t              pend_status;
  logic [TIME_BITS-1:0] pend_next;
  logic                 pend_nvalid;
  logic                 pend_more;
  logic                 pend_last;

  // Search chain: element i feeds cell i, element NUM_SLOTS is the answer.
  logic                 tok_valid  [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] tok_key    [NUM_SLOTS+1];
  logic [IW-1:0]        tok_idx    [NUM_SLOTS+1];
  logic [PER_W-1:0]     tok_per    [NUM_SLOTS+1];
  logic                 tok_paused [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] active_vec;

  cell_ctl_t            ctl;
  logic [IW-1:0]        sel_idx;
  logic [TIME_BITS-1:0] wr_exp;
  logic [TIME_BITS-1:0] add_exp;
  logic [TIME_BITS-1:0] set_val;

  logic                 out_free;
  logic                 slot_hit;
  logic                 rem_start;
  logic                 rem_done;
  logic [31:0]          rem_val;
  logic                 win_valid;
  logic                 win_paused;
  logic [TIME_BITS-1:0] win_key;
  logic [IW-1:0]        win_slot;
  logic [PER_W-1:0]     win_period;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign win_valid  = tok_valid[NUM_SLOTS];
  assign win_paused = tok_paused[NUM_SLOTS];
  assign win_key    = tok_key[NUM_SLOTS];
  assign win_slot   = tok_idx[NUM_SLOTS];
  assign win_period = tok_per[NUM_SLOTS];

  assign tok_valid[0]  = 1'b0;
  assign tok_key[0]    = '0;
  assign tok_idx[0]    = '0;
  assign tok_per[0]    = '0;
  assign tok_paused[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      tmr_cell #(
        .CELL_IDX (gi),
        .IDX_W    (IW),
        .TIME_BITS(TIME_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .sel_idx    (sel_idx),
        .wr_exp     (wr_exp),
        .wr_per     (per_q),
        .now        (now_q),
        .tin_valid  (tok_valid[gi]),
        .tin_key    (tok_key[gi]),
        .tin_idx    (tok_idx[gi]),
        .tin_per    (tok_per[gi]),
        .tin_paused (tok_paused[gi]),
        .tout_valid (tok_valid[gi+1]),
        .tout_key   (tok_key[gi+1]),
        .tout_idx   (tok_idx[gi+1]),
        .tout_per   (tok_per[gi+1]),
        .tout_paused(tok_paused[gi+1]),
        .active     (active_vec[gi])
      );
    end
  endgenerate

  // A paused periodic timer skips ahead to its first expiry after now.
  assign rem_start = (state == S_DECIDE) && (scan_mode == SCAN_DUE) && win_valid &&
                     win_paused && (win_period != '0);

  tmr_rem #(
    .TIME_BITS(TIME_BITS)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(now_q - win_key),
    .divisor (win_period),
    .done    (rem_done),
    .rem     (rem_val)
  );

  assign add_exp = (op_q == OP_ADD_AT) ? tv_q : (now_q + tv_q);
  assign set_val = now_q - TIME_BITS'(rem_val) + TIME_BITS'(win_per);

  // The addressed slot of a pause, resume or cancel must exist and be in use.
  assign slot_hit = (32'(slot) < NUM_SLOTS) && active_vec[IW'(slot)];

  // Slot updates sent down the row.
  always_comb begin
    ctl.cmd  = CMD_NONE;
    ctl.mode = scan_mode;
    sel_idx  = pend_idx;
    wr_exp   = add_exp;
    case (state)
      S_IDLE: begin
        if (in_valid && (op_t'(operation) == OP_RUN)) ctl.cmd = CMD_CLR_SEEN;
      end
      S_DECIDE: begin
        if ((scan_mode == SCAN_DUE) && win_valid && win_paused && (win_period == '0)) begin
          ctl.cmd = CMD_FREE;
          sel_idx = win_slot;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          ctl.cmd = CMD_SET_EXP;
          sel_idx = win_idx;
          wr_exp  = set_val;
        end
      end
      S_EMIT: begin
        if (out_free) ctl.cmd = pend_cmd;
      end
      default: ;
    endcase
  end

  // The output register is loaded from the staged result and drops once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_mode  <= SCAN_FREE;
      scan_cnt   <= '0;
      active_cnt <= '0;
      fires      <= '0;
      more       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op_t'(operation);
            tv_q  <= time_value;
            per_q <= interval;
            now_q <= now;
            case (op_t'(operation))
              OP_ADD_AT, OP_ADD_AFTER: begin
                scan_mode <= SCAN_FREE;
                state     <= S_SCAN;
              end
              OP_PAUSE, OP_RESUME, OP_CANCEL: begin
                pend_idx    <= IW'(slot);
                pend_kind   <= KIND_ACK;
                pend_slot   <= slot;
                pend_next   <= '0;
                pend_nvalid <= 1'b0;
                pend_more   <= 1'b0;
                pend_last   <= 1'b1;
                pend_cnt    <= active_cnt;
                if (!slot_hit) begin
                  pend_cmd    <= CMD_NONE;
                  pend_status <= ST_INACTIVE;
                end else begin
                  pend_status <= ST_OK;
                  if (op_t'(operation) == OP_PAUSE) begin
                    pend_cmd <= CMD_PAUSE;
                  end else if (op_t'(operation) == OP_RESUME) begin
                    pend_cmd <= CMD_RESUME;
                  end else begin
                    pend_cmd <= CMD_FREE;
                    pend_cnt <= active_cnt - 1'b1;
                  end
                end
                state <= S_EMIT;
              end
              OP_RUN: begin
                fires     <= '0;
                more      <= 1'b0;
                scan_mode <= SCAN_DUE;
                state     <= S_SCAN;
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (scan_cnt == IW'(NUM_SLOTS - 1)) begin
            scan_cnt <= '0;
            state    <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end

        S_DECIDE: begin
          win_idx     <= win_slot;
          win_per     <= win_period;
          pend_idx    <= win_slot;
          pend_next   <= '0;
          pend_nvalid <= 1'b0;
          pend_more   <= 1'b0;
          pend_status <= ST_OK;
          case (scan_mode)
            SCAN_FREE: begin
              pend_kind <= KIND_ACK;
              pend_last <= 1'b1;
              if (win_valid) begin
                pend_cmd  <= CMD_ADD;
                pend_slot <= SLOT_W'(win_slot);
                pend_cnt  <= active_cnt + 1'b1;
              end else begin
                pend_cmd    <= CMD_NONE;
                pend_slot   <= '0;
                pend_status <= ST_FULL;
                pend_cnt    <= active_cnt;
              end
              state <= S_EMIT;
            end
            SCAN_DUE: begin
              if (!win_valid) begin
                scan_mode <= SCAN_NEXT;
                state     <= S_SCAN;
              end else if (win_paused) begin
                // Paused one-shot timers are freed here without a result.
                if (win_period == '0) begin
                  active_cnt <= active_cnt - 1'b1;
                  state      <= S_SCAN;
                end else begin
                  state <= S_DIV;
                end
              end else if (fires == FW'(MAX_FIRE)) begin
                more      <= 1'b1;
                scan_mode <= SCAN_NEXT;
                state     <= S_SCAN;
              end else begin
                pend_kind <= KIND_FIRE;
                pend_slot <= SLOT_W'(win_slot);
                pend_last <= 1'b0;
                if (win_period == '0) begin
                  pend_cmd <= CMD_FREE;
                  pend_cnt <= active_cnt - 1'b1;
                end else begin
                  pend_cmd <= CMD_ADVANCE;
                  pend_cnt <= active_cnt;
                end
                fires <= fires + 1'b1;
                state <= S_EMIT;
              end
            end
            SCAN_NEXT: begin
              pend_cmd    <= CMD_NONE;
              pend_kind   <= KIND_DONE;
              pend_slot   <= '0;
              pend_next   <= win_valid ? win_key : '0;
              pend_nvalid <= win_valid;
              pend_more   <= more;
              pend_last   <= 1'b1;
              pend_cnt    <= active_cnt;
              state       <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_DIV: begin
          if (rem_done) begin
            scan_mode <= SCAN_DUE;
            state     <= S_SCAN;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            kind         <= pend_kind;
            slot_out     <= pend_slot;
            status       <= pend_status;
            next_expiry  <= pend_next;
            next_valid   <= pend_nvalid;
            more_pending <= pend_more;
            last         <= pend_last;
            active_count <= (32'(pend_cnt) > 127) ? CNT_OUT_W'(127) : CNT_OUT_W'(pend_cnt);
            active_cnt   <= pend_cnt;
            scan_mode    <= SCAN_DUE;
            state        <= pend_last ? S_IDLE : S_SCAN;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The running count must always agree with the active marks held in the row.
  `TMR_ASSERT_IMPL(a_cnt_match, 1'b1, $countones(active_vec) == 32'(active_cnt))
  `TMR_ASSERT_IMPL(a_rem_in_div, rem_done, state == S_DIV)
  `TMR_ASSERT_IMPL(a_fire_bound, 1'b1, 32'(fires) <= MAX_FIRE)

endmodule
`default_nettype wire

// ----- rtl/core/tmr_cell.sv -----
`default_nettype none
// One timer slot plus one stage of the search chain.
module tmr_cell #(
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = 6,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmr_pkg::cell_ctl_t   ctl,
  input  logic [IDX_W-1:0]     sel_idx,
  input  logic [TIME_BITS-1:0] wr_exp,
  input  logic [31:0]          wr_per,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 tin_valid,
  input  logic [TIME_BITS-1:0] tin_key,
  input  logic [IDX_W-1:0]     tin_idx,
  input  logic [31:0]          tin_per,
  input  logic                 tin_paused,
  output logic                 tout_valid,
  output logic [TIME_BITS-1:0] tout_key,
  output logic [IDX_W-1:0]     tout_idx,
  output logic [31:0]          tout_per,
  output logic                 tout_paused,
  output logic                 active
);
  import tmr_pkg::*;

  logic                 paused;
  logic                 seen;
  logic [TIME_BITS-1:0] expiry;
  logic [31:0]          period;
  logic                 sel;
  logic                 cand;
  logic                 take;
  logic [TIME_BITS-1:0] key;

  assign sel = (sel_idx == IDX_W'(CELL_IDX));

  always_comb begin
    case (ctl.mode)
      SCAN_FREE: begin
        cand = !active;
        key  = '0;
      end
      SCAN_DUE: begin
        cand = active && !seen && (expiry <= now);
        key  = expiry;
      end
      SCAN_NEXT: begin
        cand = active;
        key  = expiry;
      end
      default: begin
        cand = 1'b0;
        key  = expiry;
      end
    endcase
  end

  // Strictly smaller wins, so on a tie the lower slot already in the token stays.
  assign take = cand && (!tin_valid || (key < tin_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_valid <= 1'b0;
    end else begin
      tout_valid <= tin_valid || cand;
    end
    if (take) begin
      tout_key    <= key;
      tout_idx    <= IDX_W'(CELL_IDX);
      tout_per    <= period;
      tout_paused <= paused;
    end else begin
      tout_key    <= tin_key;
      tout_idx    <= tin_idx;
      tout_per    <= tin_per;
      tout_paused <= tin_paused;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      seen   <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_ADD: if (sel) begin
          active <= 1'b1;
          paused <= 1'b0;
          expiry <= wr_exp;
          period <= wr_per;
        end
        CMD_PAUSE:   if (sel) paused <= 1'b1;
        CMD_RESUME:  if (sel) paused <= 1'b0;
        CMD_FREE:    if (sel) active <= 1'b0;
        CMD_ADVANCE: if (sel) expiry <= expiry + TIME_BITS'(period);
        CMD_SET_EXP: if (sel) begin
          expiry <= wr_exp;
          seen   <= 1'b1;
        end
        CMD_CLR_SEEN: seen <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tmr_rem.sv -----
`default_nettype none
`include "assert_macros.svh"
// Bit-serial restoring remainder, one dividend bit per cycle.
module tmr_rem #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [31:0]          divisor,
  output logic                 done,
  output logic [31:0]          rem
);
  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] dvd;
  logic [31:0]          dvs;
  logic [32:0]          trial;

  assign trial = {rem, dvd[TIME_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (trial >= {1'b0, dvs}) begin
          rem <= 32'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[31:0];
        end
        if (cnt == CNT_W'(TIME_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  `TMR_ASSERT_NEXT(a_start_busy, start, busy || done)
  `TMR_ASSERT_IMPL(a_rem_below, done && (dvs != 32'd0), rem < dvs)

endmodule
`default_nettype wire
